[hdl/rgba_box_downsample_2x2_defines.svh]
// Assertion macros for the downsampler RTL.
// The clock is clk_i and the active-low reset is rst_ni in every user.
`ifndef RGBA_BOX_DOWNSAMPLE_2X2_DEFINES_SVH
`define RGBA_BOX_DOWNSAMPLE_2X2_DEFINES_SVH

`ifndef SYNTHESIS

`define RBD_ASSERT(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

`define RBD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define RBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RBD_ASSERT(label, expr)
`define RBD_ASSERT_IMPL(label, ante, cons)
`define RBD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/rbd_pkg.sv]
package rbd_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int CfgW      = 13;
  localparam int ChanW     = 8;
  localparam int SumW      = ChanW + 1;
  localparam int NumChan   = 4;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int LineDepth = MaxWidth / 2;
  localparam int SlotW     = $clog2(LineDepth);
  localparam int WDimW     = ColW + 1;
  localparam int HDimW     = RowW + 1;

  typedef enum logic [0:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_alpha;
  } in_pix_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
    logic             frame_end;
  } out_pix_t;

  typedef logic [NumChan-1:0][ChanW-1:0] chan_t;
  typedef logic [NumChan-1:0][SumW-1:0]  pair_t;

  function automatic chan_t to_chan(in_pix_t p);
    chan_t c;
    c[0] = p.in_red;
    c[1] = p.in_green;
    c[2] = p.in_blue;
    c[3] = p.in_alpha;
    return c;
  endfunction

  function automatic pair_t pair_sum(chan_t a, chan_t b);
    pair_t s;
    for (int i = 0; i < NumChan; i++) begin
      s[i] = {1'b0, a[i]} + {1'b0, b[i]};
    end
    return s;
  endfunction

endpackage

[hdl/rbd_ram.sv]
module rbd_ram #(
  parameter int Width = 36,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/rgba_box_downsample_2x2.sv]
// 2x2 box-filter downsampler for an RGBA8 raster stream.
// Source pixels enter on the in channel (in_valid_i, in_stall_o, in_pix_i),
// one beat per pixel in raster order. Averaged pixels leave on the out
// channel (out_valid_o, out_stall_i, out_pix_o); frame_end marks the last
// beat of each reduced frame. Image width and height are set through the
// write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user must write them
// only while the block is idle, which the block itself does not enforce.
// A beat is taken every clock as long as the receiver keeps up. A result
// passes the read stage (line store read), then the output register. The
// line store is a single RAM with one write and one read port; no beat both
// writes and reads it, so throughput is one pixel per cycle if not stalled.
// When the receiver stalls, one result waits in the output register and one
// more in the read stage; only then is the input stalled.
// Reset clears the counters, the held pixel and both valid flags and sets
// width and height to one. The line store is not cleared: even rows write
// each entry before odd rows read it.
module rgba_box_downsample_2x2 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [12:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rbd_pkg::in_pix_t     in_pix_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rbd_pkg::out_pix_t    out_pix_o
);

  import rbd_pkg::*;

  `include "rgba_box_downsample_2x2_defines.svh"

  logic [CfgW-1:0]  width_q, width_d;
  logic [CfgW-1:0]  height_q, height_d;
  logic [WDimW-1:0] w_eff;
  logic [HDimW-1:0] h_eff;
  logic             w_one, h_one;
  logic [WDimW-1:0] w_even;
  logic [HDimW-1:0] h_even;
  logic [SlotW-1:0] nw_m1;
  logic [RowW-2:0]  nh_m1;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  chan_t            held_q, held_d;
  chan_t            pix;

  logic             col_ok, row_ok, pix_ok, have_pair, emit, last;
  pair_t            ps;
  logic             in_acc;
  logic             ram_we, ram_re;
  logic [SlotW-1:0] slot;
  pair_t            ram_rdata;

  logic             s1_valid_q, s1_valid_d;
  pair_t            s1_ps_q, s1_ps_d;
  logic             s1_use_ram_q, s1_use_ram_d;
  logic             s1_last_q, s1_last_d;
  logic             s1_move;

  pair_t            other;
  chan_t            avg;
  logic             out_valid_q, out_valid_d;
  out_pix_t         out_q, out_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth:  width_d  = cfg_data_i;
        CfgImageHeight: height_d = cfg_data_i;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WDimW'(1);
    end else if (32'(width_q) > 32'(MaxWidth)) begin
      w_eff = WDimW'(MaxWidth);
    end else begin
      w_eff = WDimW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HDimW'(1);
    end else if (32'(height_q) > 32'(MaxHeight)) begin
      h_eff = HDimW'(MaxHeight);
    end else begin
      h_eff = HDimW'(height_q);
    end
  end

  assign w_one  = (w_eff == WDimW'(1));
  assign h_one  = (h_eff == HDimW'(1));
  assign w_even = {w_eff[WDimW-1:1], 1'b0};
  assign h_even = {h_eff[HDimW-1:1], 1'b0};
  assign nw_m1  = w_one ? '0 : SlotW'(w_eff[WDimW-1:1] - 1'b1);
  assign nh_m1  = h_one ? '0 : (RowW-1)'(h_eff[HDimW-1:1] - 1'b1);

  assign pix       = to_chan(in_pix_i);
  assign col_ok    = w_one ? (col_q == '0) : ({1'b0, col_q} < w_even);
  assign row_ok    = h_one ? (row_q == '0) : ({1'b0, row_q} < h_even);
  assign pix_ok    = col_ok && row_ok;
  assign have_pair = pix_ok && (w_one || col_q[0]);
  assign emit      = have_pair && (h_one || row_q[0]);
  assign ps        = w_one ? pair_sum(pix, pix) : pair_sum(held_q, pix);
  assign slot      = SlotW'(col_q[ColW-1:1]);
  assign last      = (col_q[ColW-1:1] == (ColW-1)'(nw_m1)) && (row_q[RowW-1:1] == nh_m1);

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ram_we     = in_acc && have_pair && !h_one && !row_q[0];
  assign ram_re     = in_acc && emit && !h_one;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    held_d = held_q;
    if (in_acc) begin
      if (pix_ok && !w_one && !col_q[0]) begin
        held_d = pix;
      end
      if (({1'b0, col_q} + 1'b1) >= w_eff) begin
        col_d = '0;
        if (({1'b0, row_q} + 1'b1) >= h_eff) begin
          row_d = '0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  rbd_ram #(
    .Width ($bits(pair_t)),
    .Depth (LineDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (ps),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s1_ps_d      = s1_ps_q;
    s1_use_ram_d = s1_use_ram_q;
    s1_last_d    = s1_last_q;
    s1_valid_d   = s1_valid_q && !s1_move;
    if (in_acc) begin
      s1_valid_d   = emit;
      s1_ps_d      = ps;
      s1_use_ram_d = !h_one;
      s1_last_d    = last;
    end
  end

  assign other = s1_use_ram_q ? ram_rdata : s1_ps_q;

  always_comb begin
    logic [SumW:0] sum;
    for (int i = 0; i < NumChan; i++) begin
      sum    = {1'b0, s1_ps_q[i]} + {1'b0, other[i]};
      avg[i] = sum[SumW:2];
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_move) begin
      out_valid_d     = 1'b1;
      out_d.out_red   = avg[0];
      out_d.out_green = avg[1];
      out_d.out_blue  = avg[2];
      out_d.out_alpha = avg[3];
      out_d.frame_end = s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CfgW'(1);
      height_q    <= CfgW'(1);
      col_q       <= '0;
      row_q       <= '0;
      held_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      held_q      <= held_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ps_q      <= s1_ps_d;
    s1_use_ram_q <= s1_use_ram_d;
    s1_last_q    <= s1_last_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_q;

  `RBD_ASSERT(a_ram_one_port_op, !(ram_we && ram_re))
  `RBD_ASSERT_IMPL(a_empty_stage_no_stall, !s1_valid_q, !in_stall_o)
  `RBD_ASSERT_NEXT(a_read_lands_in_stage, ram_re, s1_valid_q && s1_use_ram_q)
  `RBD_ASSERT_IMPL(a_full_pipe_stalls, s1_valid_q && out_valid_q && out_stall_i, in_stall_o)

endmodule

[dv/rgba_box_downsample_2x2_tb.sv]
`timescale 1ns / 1ps

module rgba_box_downsample_2x2_tb;
  import rbd_pkg::*;

  localparam int CycleLimit  = 500_000;
  localparam int DrainCycles = 8;
  localparam int PhaseItems  = 340;

  typedef logic [NumChan-1:0][SumW-1:0] lane_sums_t;
  typedef logic [ChanW-1:0] chan_vals_t [NumChan];

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [0:0]        cfg_idx   = '0;
  logic [CfgW-1:0]   cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_pix_t           in_pix    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_pix_t          out_pix;

  logic [CfgW-1:0]   size_w;
  logic [CfgW-1:0]   size_h;
  chan_vals_t        held_chan;
  int unsigned       col_pos;
  int unsigned       row_pos;
  lane_sums_t        line_sums [LineDepth];
  out_pix_t          pending_averages [$];

  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int                send_idle_pct = 0;
  int                stall_pct = 0;

  rgba_box_downsample_2x2 i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_pix_i   (in_pix),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_pix_o  (out_pix)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(logic [CfgW-1:0] v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  function automatic void box_average_step(in_pix_t p);
    int unsigned w;
    int unsigned h;
    int unsigned nw;
    int unsigned nh;
    int unsigned x;
    int unsigned y;
    chan_vals_t cur;
    chan_vals_t avg;
    lane_sums_t ps;
    lane_sums_t other;
    bit have_pair;
    bit emit;
    out_pix_t r;
    w = clamp_dim(size_w, MaxWidth);
    h = clamp_dim(size_h, MaxHeight);
    nw = (w / 2 != 0) ? w / 2 : 1;
    nh = (h / 2 != 0) ? h / 2 : 1;
    x = col_pos;
    y = row_pos;
    cur[0] = p.in_red;
    cur[1] = p.in_green;
    cur[2] = p.in_blue;
    cur[3] = p.in_alpha;
    have_pair = 1'b0;
    emit = 1'b0;
    ps = '0;
    other = '0;
    if (((w == 1) ? (x == 0) : (x < 2 * nw)) && ((h == 1) ? (y == 0) : (y < 2 * nh))) begin
      if (w == 1) begin
        for (int c = 0; c < NumChan; c++) ps[c] = {1'b0, cur[c]} + {1'b0, cur[c]};
        have_pair = 1'b1;
      end else if (x % 2 == 0) begin
        held_chan = cur;
      end else begin
        for (int c = 0; c < NumChan; c++) ps[c] = {1'b0, held_chan[c]} + {1'b0, cur[c]};
        have_pair = 1'b1;
      end
      if (have_pair) begin
        if (h == 1) begin
          other = ps;
          emit = 1'b1;
        end else if (y % 2 == 0) begin
          line_sums[SlotW'((x / 2) % LineDepth)] = ps;
        end else begin
          other = line_sums[SlotW'((x / 2) % LineDepth)];
          emit = 1'b1;
        end
      end
      if (emit) begin
        for (int c = 0; c < NumChan; c++) begin
          avg[c] = ChanW'(({1'b0, ps[c]} + {1'b0, other[c]}) >> 2);
        end
        r.out_red   = avg[0];
        r.out_green = avg[1];
        r.out_blue  = avg[2];
        r.out_alpha = avg[3];
        r.frame_end = (x / 2 == nw - 1) && (y / 2 == nh - 1);
        pending_averages = {pending_averages, r};
      end
    end
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  function automatic in_pix_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic [7:0] a);
    in_pix_t p;
    p.in_red   = r;
    p.in_green = g;
    p.in_blue  = b;
    p.in_alpha = a;
    return p;
  endfunction

  function automatic logic [ChanW-1:0] rand_chan();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return ChanW'($urandom_range(255));
  endfunction

  function automatic in_pix_t rand_pixel();
    return make_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
  endfunction

  function automatic void check_field(string name, logic [ChanW-1:0] want,
                                      logic [ChanW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_pixel(in_pix_t p);
    in_valid <= 1'b1;
    in_pix   <= p;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    box_average_step(p);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_random_pixels(int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgImageWidth) size_w = val;
    else size_h = val;
    @(posedge clk_i);
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    wait_idle();
    write_reg(CfgImageWidth, CfgW'(w));
    write_reg(CfgImageHeight, CfgW'(h));
  endtask

  task automatic send_frames(int unsigned frames);
    send_random_pixels(frames * clamp_dim(size_w, MaxWidth) * clamp_dim(size_h, MaxHeight));
  endtask

  // Both sizes start at one, so every pixel is its own reduced frame.
  task automatic test_reset_sizes();
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff));
  endtask

  task automatic test_odd_trailing();
    set_size(3, 3);
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(rand_pixel());
    send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(make_pixel(8'hfe, 8'h01, 8'h00, 8'h03));
    send_random_pixels(4);
  endtask

  task automatic test_single_line();
    set_size(1, 3);
    send_frames(1);
    set_size(3, 1);
    send_frames(1);
  endtask

  task automatic test_zero_size();
    set_size(0, 0);
    send_frames(1);
  endtask

  // The width shrinks after the first pair of row zero is stored, so the
  // column counter already sits past the new width and the odd row still
  // reads a slot that was written.
  task automatic test_midframe_write();
    set_size(4, 4);
    send_random_pixels(2);
    wait_idle();
    write_reg(CfgImageWidth, CfgW'(2));
    send_random_pixels(7);
  endtask

  // Oversized registers clamp to 4096. Only the start of such a frame is
  // sent; smaller sizes then close it so the counters end at zero.
  task automatic test_oversized_sizes();
    set_size(8191, 1);
    send_random_pixels(6);
    set_size(6, 1);
    send_random_pixels(1);
    set_size(1, 8191);
    send_random_pixels(4);
    set_size(1, 4);
    send_random_pixels(1);
    set_size(8191, 8191);
    send_random_pixels(40);
    set_size(40, 2);
    send_random_pixels(41);
  endtask

  function automatic int unsigned pick_dim(int unsigned top);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return 0;
    if (sel < 55) return $urandom_range(4, 1);
    if (sel < 90) return $urandom_range(12, 5);
    return $urandom_range(top, 13);
  endfunction

  task automatic test_random_phase(int idle_pct, int stall, int unsigned n_items);
    int unsigned sent;
    int unsigned frames;
    int unsigned frame_px;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      set_size(pick_dim(40), pick_dim(16));
      frame_px = clamp_dim(size_w, MaxWidth) * clamp_dim(size_h, MaxHeight);
      frames = $urandom_range(3, 1);
      if (frames * frame_px > n_items - sent) frames = 1;
      send_frames(frames);
      sent += frames * frame_px;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    out_pix_t want;
    if (rst_ni && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_averages.size() == 0) begin
        $error("output beat with no expected average");
        error_count++;
      end else begin
        want = pending_averages.pop_front();
        check_field("out_red", want.out_red, out_pix.out_red);
        check_field("out_green", want.out_green, out_pix.out_green);
        check_field("out_blue", want.out_blue, out_pix.out_blue);
        check_field("out_alpha", want.out_alpha, out_pix.out_alpha);
        check_field("frame_end", ChanW'(want.frame_end), ChanW'(out_pix.frame_end));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    size_w = 1;
    size_h = 1;
    col_pos = 0;
    row_pos = 0;
    for (int c = 0; c < NumChan; c++) held_chan[c] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_sizes();
    test_odd_trailing();
    test_single_line();
    test_zero_size();
    test_midframe_write();
    test_oversized_sizes();
    test_random_phase(0, 0, PhaseItems);
    test_random_phase(80, 0, PhaseItems);
    test_random_phase(0, 80, PhaseItems);
    test_random_phase(28, 28, PhaseItems);
    wait_idle();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
